>>> src/lpi_pkg.sv
`default_nettype none

package lpi_pkg;

  localparam int unsigned TOL_WIDTH    = 16;
  localparam int unsigned CMD_WIDTH    = 2;
  localparam int unsigned STATUS_WIDTH = 3;

  localparam logic [CMD_WIDTH-1:0] CMD_LOAD      = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_ISECT     = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_ISECT_BOX = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_VERT     = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_PARALLEL = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_DEGEN    = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_OUTSIDE  = 3'd4;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 3'd5;

  // main sequencer
  typedef enum logic [3:0] {
    TS_IDLE,
    TS_CHECK,
    TS_MULGO,
    TS_MUL,
    TS_DCAP,
    TS_NCAP,
    TS_DIVGO,
    TS_DIV,
    TS_BOX,
    TS_OUT
  } top_state_e;

  // which product / quotient the shared unit is working on
  typedef enum logic [2:0] {
    PH_D1,   // dx1*dy2
    PH_D2,   // dy1*dx2
    PH_N1,   // (px2-px1)*dy2
    PH_N2,   // (py2-py1)*dx2
    PH_AX,   // dx1*N, then x
    PH_AY,   // dy1*N, then y
    PH_AV    // one line vertical
  } phase_e;

  typedef enum logic [1:0] {
    US_IDLE,
    US_MUL,
    US_DCHK,
    US_DIV
  } unit_state_e;

  typedef struct packed {
    logic mul_start;
    logic div_start;
  } unit_ctrl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } unit_stat_t;

endpackage

`default_nettype wire

>>> src/lpi_serial_unit.sv
`default_nettype none

module lpi_serial_unit #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpi_pkg::unit_ctrl_t ctrl_i,
  input  logic [3*W+1:0]      op_a_i,
  input  logic [3*W+1:0]      op_b_i,
  output lpi_pkg::unit_stat_t stat_o,
  output logic [3*W+1:0]      prod_o,
  output logic [W:0]          quot_o
);
  import lpi_pkg::*;

  localparam int unsigned MW = 3 * W + 2;
  localparam int unsigned QW = W + 1;
  localparam int unsigned CW = $clog2(W + 2);
  localparam logic [CW-1:0] MulSteps = CW'(W);
  localparam logic [CW-1:0] DivSteps = CW'(QW);

  unit_state_e   state_q, state_d;
  logic [MW-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d, ovf_q, ovf_d;
  logic [MW-1:0] add_x, add_y;
  logic          add_sub;
  logic [MW:0]   add_s;
  logic [MW-1:0] r_shift;
  logic          last;

  assign r_shift = {r_q[MW-2:0], a_q[MW-1]};
  assign last    = (cnt_q == CW'(1));
  // when subtracting, the top bit is set for x >= y
  assign add_s   = {1'b0, add_x} + {1'b0, add_y ^ {MW{add_sub}}} + {{MW{1'b0}}, add_sub};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      US_IDLE: begin
        if (ctrl_i.mul_start) begin
          state_d = US_MUL;
        end else if (ctrl_i.div_start) begin
          state_d = US_DCHK;
        end
      end
      US_MUL:  if (last) state_d = US_IDLE;
      US_DCHK: state_d = add_s[MW] ? US_IDLE : US_DIV;
      US_DIV:  if (last) state_d = US_IDLE;
    endcase
  end

  // adder control
  always_comb begin
    add_x   = r_q;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      US_IDLE: ;
      US_MUL:  add_y = b_q[0] ? a_q : '0;
      US_DCHK: begin
        add_y   = b_q;
        add_sub = 1'b1;
      end
      US_DIV: begin
        add_x   = r_shift;
        add_y   = b_q;
        add_sub = 1'b1;
      end
    endcase
  end

  // operand registers
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    unique case (state_q)
      US_IDLE: begin
        if (ctrl_i.mul_start) begin
          a_d   = op_a_i;
          b_d   = op_b_i;
          r_d   = '0;
          cnt_d = MulSteps;
        end else if (ctrl_i.div_start) begin
          // high part must stay below the divisor, else quotient is too wide
          r_d   = op_a_i >> QW;
          a_d   = op_a_i << (MW - QW);
          b_d   = op_b_i;
          cnt_d = DivSteps;
          ovf_d = 1'b0;
        end
      end
      US_MUL: begin
        r_d    = add_s[MW-1:0];
        a_d    = a_q << 1;
        b_d    = b_q >> 1;
        cnt_d  = cnt_q - CW'(1);
        done_d = last;
      end
      US_DCHK: begin
        if (add_s[MW]) begin
          ovf_d  = 1'b1;
          done_d = 1'b1;
        end
      end
      US_DIV: begin
        r_d    = add_s[MW] ? add_s[MW-1:0] : r_shift;
        a_d    = {a_q[MW-2:0], add_s[MW]};
        cnt_d  = cnt_q - CW'(1);
        done_d = last;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= US_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign prod_o      = r_q;
  assign quot_o      = a_q[QW-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.mul_start || ctrl_i.div_start) |-> state_q == US_IDLE)
    else $error("unit started while busy");

  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.mul_start && ctrl_i.div_start))
    else $error("multiply and divide started together");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == US_IDLE)
    else $error("done flagged while unit still running");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == US_MUL || state_q == US_DIV) |-> cnt_q != '0)
    else $error("step counter ran out");

endmodule

`default_nettype wire

>>> src/line_pair_intersection_top.sv
// Line pair intersection, signed fixed point.
// Input channel (in_valid_i/in_ready_o): one request per command. A load
// request stores the first line and gives no result. An intersect request
// gives exactly one result on the output channel (out_valid_o/out_ready_i):
// crossing point and status. Command 3 is dropped. Config channel
// (cfg_valid_i/cfg_ready_o) writes the zero tolerance; it is always ready.
// The user must write it only while no request is in flight; the block
// itself does not enforce this. All products and quotients run on one
// shared shift-add multiplier / restoring divider. Degenerate or
// both-vertical lines need no product; one vertical line takes one product
// and one quotient, the general case six products and two quotients.
// in_ready_o is low while a request is worked on, so no new request is
// taken until the current one is done.
// The result sits in an output register; the next request is taken while it
// waits. A stalled receiver holds the block only when the next result is done.
// Reset clears the stored first line, the tolerance and the output valid.
`default_nettype none

module line_pair_intersection_top #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lpi_pkg::TOL_WIDTH-1:0]      zero_tolerance_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lpi_pkg::CMD_WIDTH-1:0]      command_i,
  input  logic signed [COORD_WIDTH-1:0]      line_px_i,
  input  logic signed [COORD_WIDTH-1:0]      line_py_i,
  input  logic signed [COORD_WIDTH-1:0]      line_dx_i,
  input  logic signed [COORD_WIDTH-1:0]      line_dy_i,
  input  logic signed [COORD_WIDTH-1:0]      corner_a_x_i,
  input  logic signed [COORD_WIDTH-1:0]      corner_a_y_i,
  input  logic signed [COORD_WIDTH-1:0]      corner_b_x_i,
  input  logic signed [COORD_WIDTH-1:0]      corner_b_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      cross_x_o,
  output logic signed [COORD_WIDTH-1:0]      cross_y_o,
  output logic [lpi_pkg::STATUS_WIDTH-1:0]   status_o
);
  import lpi_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned AW   = 2 * W + 2;  // signed D and N
  localparam int unsigned MAGW = 2 * W + 1;  // magnitudes of D and N
  localparam int unsigned MW   = 3 * W + 2;  // unit operand width
  localparam int unsigned QW   = W + 1;      // quotient width

  function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  top_state_e state_q, state_d;
  phase_e     phase_q, phase_d;

  logic [TOL_WIDTH-1:0] tol_q;
  logic [W-1:0] p1x_q, p1y_q, d1x_q, d1y_q;
  logic [CMD_WIDTH-1:0] cmd_q;
  logic [W-1:0] px2_q, py2_q, dx2_q, dy2_q;
  logic [W-1:0] ax_q, ay_q, bx_q, by_q;
  logic         vert1_q;
  logic [AW-1:0]   acc_q;
  logic            dsign_q, nsign_q;
  logic [MAGW-1:0] dmag_q, nmag_q;
  logic [W-1:0]    x_q, y_q;
  logic [STATUS_WIDTH-1:0] st_q;

  logic                    out_valid_q;
  logic [W-1:0]            cross_x_q, cross_y_q;
  logic [STATUS_WIDTH-1:0] status_q;

  logic iz_d1x, iz_d1y, iz_dx2, iz_dy2, degen, both_vert;
  logic [W:0] diffx, diffy, diffx_mag, diffy_mag;
  logic [W-1:0]    mul_src;
  logic            mc_neg, psign;
  logic [MAGW-1:0] mc_mag;
  logic [AW-1:0]   prod_t, prod_s, acc_abs;
  logic [MAGW-1:0] div_dm;
  logic            div_dneg, qneg;
  logic [MW-1:0]   div_num, div_den;
  logic [W-1:0]    base;
  logic [W+1:0]    base_e, q_e, v_sum;
  logic            v_fits;
  logic [W-1:0]    lx, hx, ly, hy;
  logic            outside;
  logic            out_load;

  unit_ctrl_t     u_ctrl;
  unit_stat_t     u_stat;
  logic [MW-1:0]  u_op_a, u_op_b, u_prod;
  logic [QW-1:0]  u_quot;

  // direction components at or under the tolerance count as zero
  assign iz_d1x    = mag_w(d1x_q) <= W'(tol_q);
  assign iz_d1y    = mag_w(d1y_q) <= W'(tol_q);
  assign iz_dx2    = mag_w(dx2_q) <= W'(tol_q);
  assign iz_dy2    = mag_w(dy2_q) <= W'(tol_q);
  assign degen     = (iz_d1x && iz_d1y) || (iz_dx2 && iz_dy2);
  assign both_vert = iz_d1x && iz_dx2;

  assign diffx     = {px2_q[W-1], px2_q} - {p1x_q[W-1], p1x_q};
  assign diffy     = {py2_q[W-1], py2_q} - {p1y_q[W-1], p1y_q};
  assign diffx_mag = diffx[W] ? (~diffx + 1'b1) : diffx;
  assign diffy_mag = diffy[W] ? (~diffy + 1'b1) : diffy;

  // product operands by phase: multiplier is always a direction component
  always_comb begin
    mul_src = d1x_q;
    mc_neg  = 1'b0;
    mc_mag  = '0;
    unique case (phase_q)
      PH_D1: begin
        mul_src = d1x_q;
        mc_neg  = dy2_q[W-1];
        mc_mag  = MAGW'(mag_w(dy2_q));
      end
      PH_D2: begin
        mul_src = d1y_q;
        mc_neg  = dx2_q[W-1];
        mc_mag  = MAGW'(mag_w(dx2_q));
      end
      PH_N1: begin
        mul_src = dy2_q;
        mc_neg  = diffx[W];
        mc_mag  = MAGW'(diffx_mag);
      end
      PH_N2: begin
        mul_src = dx2_q;
        mc_neg  = diffy[W];
        mc_mag  = MAGW'(diffy_mag);
      end
      PH_AX: begin
        mul_src = d1x_q;
        mc_neg  = nsign_q;
        mc_mag  = nmag_q;
      end
      PH_AY: begin
        mul_src = d1y_q;
        mc_neg  = nsign_q;
        mc_mag  = nmag_q;
      end
      PH_AV: begin
        // first line vertical: (px1 - px2) * dy2, else (px2 - px1) * dy1
        mul_src = vert1_q ? dy2_q : d1y_q;
        mc_neg  = diffx[W] ^ vert1_q;
        mc_mag  = MAGW'(diffx_mag);
      end
    endcase
  end

  assign psign  = mul_src[W-1] ^ mc_neg;
  assign prod_t = u_prod[AW-1:0];
  assign prod_s = psign ? (~prod_t + 1'b1) : prod_t;
  assign acc_abs = acc_q[AW-1] ? (~acc_q + 1'b1) : acc_q;

  // rounded quotient: floor((2|a| + |b|) / 2|b|)
  assign div_dm   = (phase_q == PH_AV) ? MAGW'(mag_w(vert1_q ? dx2_q : d1x_q)) : dmag_q;
  assign div_dneg = (phase_q == PH_AV) ? (vert1_q ? dx2_q[W-1] : d1x_q[W-1]) : dsign_q;
  assign qneg     = psign ^ div_dneg;
  assign div_num  = (u_prod << 1) + MW'(div_dm);
  assign div_den  = MW'(div_dm) << 1;

  assign u_op_a = (state_q == TS_DIVGO) ? div_num : MW'(mc_mag);
  assign u_op_b = (state_q == TS_DIVGO) ? div_den : MW'(mag_w(mul_src));

  always_comb begin
    unique case (phase_q)
      PH_AX:   base = p1x_q;
      PH_AY:   base = p1y_q;
      default: base = vert1_q ? py2_q : p1y_q;
    endcase
  end

  assign base_e = {{2{base[W-1]}}, base};
  assign q_e    = {1'b0, u_quot};
  assign v_sum  = qneg ? (base_e - q_e) : (base_e + q_e);
  assign v_fits = (v_sum[W+1] == v_sum[W]) && (v_sum[W] == v_sum[W-1]);

  // closed box from the two corners
  assign lx = ($signed(ax_q) < $signed(bx_q)) ? ax_q : bx_q;
  assign hx = ($signed(ax_q) < $signed(bx_q)) ? bx_q : ax_q;
  assign ly = ($signed(ay_q) < $signed(by_q)) ? ay_q : by_q;
  assign hy = ($signed(ay_q) < $signed(by_q)) ? by_q : ay_q;
  assign outside = ($signed(x_q) < $signed(lx)) || ($signed(x_q) > $signed(hx)) ||
                   ($signed(y_q) < $signed(ly)) || ($signed(y_q) > $signed(hy));

  lpi_serial_unit #(
    .W (W)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (u_ctrl),
    .op_a_i (u_op_a),
    .op_b_i (u_op_b),
    .stat_o (u_stat),
    .prod_o (u_prod),
    .quot_o (u_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      TS_IDLE: begin
        if (in_valid_i && (command_i == CMD_ISECT || command_i == CMD_ISECT_BOX)) begin
          state_d = TS_CHECK;
        end
      end
      TS_CHECK: begin
        if (degen || both_vert) begin
          state_d = TS_OUT;
        end else begin
          state_d = TS_MULGO;
          phase_d = (iz_d1x || iz_dx2) ? PH_AV : PH_D1;
        end
      end
      TS_MULGO: state_d = TS_MUL;
      TS_MUL: begin
        if (u_stat.done) begin
          unique case (phase_q)
            PH_D1: begin
              phase_d = PH_D2;
              state_d = TS_MULGO;
            end
            PH_D2: state_d = TS_DCAP;
            PH_N1: begin
              phase_d = PH_N2;
              state_d = TS_MULGO;
            end
            PH_N2: state_d = TS_NCAP;
            PH_AX, PH_AY, PH_AV: state_d = TS_DIVGO;
          endcase
        end
      end
      TS_DCAP: begin
        if (acc_q == '0) begin
          state_d = TS_OUT;
        end else begin
          phase_d = PH_N1;
          state_d = TS_MULGO;
        end
      end
      TS_NCAP: begin
        phase_d = PH_AX;
        state_d = TS_MULGO;
      end
      TS_DIVGO: state_d = TS_DIV;
      TS_DIV: begin
        if (u_stat.done) begin
          priority if (u_stat.ovf || !v_fits) begin
            state_d = TS_OUT;
          end else if (phase_q == PH_AX) begin
            phase_d = PH_AY;
            state_d = TS_MULGO;
          end else begin
            state_d = TS_BOX;
          end
        end
      end
      TS_BOX: state_d = TS_OUT;
      TS_OUT: if (!out_valid_q || out_ready_i) state_d = TS_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o       = (state_q == TS_IDLE);
    u_ctrl.mul_start = (state_q == TS_MULGO);
    u_ctrl.div_start = (state_q == TS_DIVGO);
    out_load         = (state_q == TS_OUT) && (!out_valid_q || out_ready_i);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      phase_q     <= PH_D1;
      tol_q       <= '0;
      p1x_q       <= '0;
      p1y_q       <= '0;
      d1x_q       <= '0;
      d1y_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= zero_tolerance_i;
      end
      if (in_valid_i && in_ready_o && command_i == CMD_LOAD) begin
        p1x_q <= line_px_i;
        p1y_q <= line_py_i;
        d1x_q <= line_dx_i;
        d1y_q <= line_dy_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      px2_q <= line_px_i;
      py2_q <= line_py_i;
      dx2_q <= line_dx_i;
      dy2_q <= line_dy_i;
      ax_q  <= corner_a_x_i;
      ay_q  <= corner_a_y_i;
      bx_q  <= corner_b_x_i;
      by_q  <= corner_b_y_i;
    end
    if (state_q == TS_CHECK) begin
      vert1_q <= iz_d1x;
      st_q    <= degen ? ST_DEGEN : (both_vert ? ST_VERT : ST_HIT);
    end
    if (state_q == TS_MUL && u_stat.done) begin
      if (phase_q == PH_D1 || phase_q == PH_N1) begin
        acc_q <= prod_s;
      end else if (phase_q == PH_D2 || phase_q == PH_N2) begin
        acc_q <= acc_q - prod_s;
      end
    end
    if (state_q == TS_DCAP) begin
      dsign_q <= acc_q[AW-1];
      dmag_q  <= acc_abs[MAGW-1:0];
      if (acc_q == '0) begin
        st_q <= ST_PARALLEL;
      end
    end
    if (state_q == TS_NCAP) begin
      nsign_q <= acc_q[AW-1];
      nmag_q  <= acc_abs[MAGW-1:0];
    end
    if (state_q == TS_DIV && u_stat.done) begin
      if (u_stat.ovf || !v_fits) begin
        st_q <= ST_OVERFLOW;
      end
      unique case (phase_q)
        PH_AX: x_q <= v_sum[W-1:0];
        PH_AY: y_q <= v_sum[W-1:0];
        default: begin
          x_q <= vert1_q ? p1x_q : px2_q;
          y_q <= v_sum[W-1:0];
        end
      endcase
    end
    if (state_q == TS_BOX && cmd_q == CMD_ISECT_BOX && outside) begin
      st_q <= ST_OUTSIDE;
    end
    if (out_load) begin
      cross_x_q <= (st_q == ST_HIT) ? x_q : '0;
      cross_y_q <= (st_q == ST_HIT) ? y_q : '0;
      status_q  <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cross_x_o   = cross_x_q;
  assign cross_y_o   = cross_y_q;
  assign status_o    = status_q;

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_stat.done |-> (state_q == TS_MUL || state_q == TS_DIV))
    else $error("arithmetic unit finished with nobody waiting");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_HIT) |-> (cross_x_o == '0 && cross_y_o == '0))
    else $error("nonzero point on a miss");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_OVERFLOW)
    else $error("status code out of range");

  a_first_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != TS_IDLE) |=> ($stable(p1x_q) && $stable(p1y_q) &&
                              $stable(d1x_q) && $stable(d1y_q)))
    else $error("first line changed during an intersect");

endmodule

`default_nettype wire
